// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge, reset included
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// checked outside reset
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

  localparam int DEPTH        = 64;
  localparam int DATA_W       = 32;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int CAP_W        = 7;
  localparam int COUNT_W      = $clog2(DEPTH + 1);
  localparam int STACK_ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int APB_DATA_W   = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_SEL_W    = PADDR_W - 2;

  localparam logic [REG_SEL_W-1:0] REG_CAPACITY = '0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    rd_top;
    logic    rd_next;
    logic    ld_nodata;
    logic    ld_ram;
    logic    last;
    status_t status;
  } bls_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic ptr_zero;
    logic out_last;
  } bls_stat_t;

endpackage

// ----- rtl/bounded_lifo_stack_unit.sv -----
// Bounded LIFO stack of signed 32-bit words, up to 64 entries, with the
// capacity register at APB address 0 (reset 64; 0 acts as 1, values above 64
// act as 64). One item is taken at a time: a push, and any operation on an
// empty stack, gives its result in the cycle after acceptance, and the next
// item can be taken once that result has left the output. A pop or peek adds
// a registered read of the stack memory before its result. A dump of N
// entries gives N results, top first, each after its own registered read of
// the stack memory, and holds off new items until the last result has left.
`timescale 1ns / 1ps

module bounded_lifo_stack_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bls_pkg::OPCODE_W-1:0]         opcode,
  input  logic signed [bls_pkg::DATA_W-1:0]    push_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bls_pkg::DATA_W-1:0]    data_value,
  output logic [bls_pkg::STATUS_W-1:0]         status,
  output logic                                 is_empty,
  output logic                                 is_full,
  output logic                                 last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bls_pkg::PADDR_W-1:0]          paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import bls_pkg::*;

  bls_cmd_t  cmd;
  bls_stat_t stat;

  assign pready = 1'b1;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bls_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .push_value (push_value),
    .cmd        (cmd),
    .stat       (stat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .data_value (data_value),
    .status     (status),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .last       (last)
  );

endmodule

// ----- rtl/bls_ram.sv -----
`timescale 1ns / 1ps

module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bls_ctrl.sv -----
`timescale 1ns / 1ps

module bls_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bls_pkg::OPCODE_W-1:0]      opcode,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  bls_pkg::bls_stat_t                stat,
  output bls_pkg::bls_cmd_t                 cmd
);

  import bls_pkg::*;

  state_t  state, state_next;
  opcode_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.status = ST_OK;
    in_stall   = (state != S_IDLE);
    out_valid  = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next = opcode_t'(opcode);
          unique case (opcode_t'(opcode))
            OP_PUSH: begin
              cmd.ld_nodata = 1'b1;
              if (stat.full) begin
                cmd.status = ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
              state_next = S_OUT;
            end
            OP_POP, OP_PEEK, OP_DUMP: begin
              if (stat.cnt_zero) begin
                cmd.ld_nodata = 1'b1;
                cmd.status    = ST_UNDERFLOW;
                state_next    = S_OUT;
              end else begin
                cmd.rd_top = 1'b1;
                cmd.pop    = (opcode_t'(opcode) == OP_POP);
                state_next = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cmd.ld_ram = 1'b1;
        cmd.last   = (op != OP_DUMP) || stat.ptr_zero;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (!stat.out_last) begin
            cmd.rd_next = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bls_dp.sv -----
`timescale 1ns / 1ps

module bls_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [bls_pkg::DATA_W-1:0]    push_value,
  input  bls_pkg::bls_cmd_t                    cmd,
  output bls_pkg::bls_stat_t                   stat,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bls_pkg::PADDR_W-1:0]          paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0]       prdata,
  output logic signed [bls_pkg::DATA_W-1:0]    data_value,
  output logic [bls_pkg::STATUS_W-1:0]         status,
  output logic                                 is_empty,
  output logic                                 is_full,
  output logic                                 last
);

  import bls_pkg::*;

  logic [CAP_W-1:0]        capacity;
  logic [COUNT_W-1:0]      count, count_next;
  logic [COUNT_W-1:0]      eff_cap;
  logic [COUNT_W-1:0]      count_dec;
  logic [STACK_ADDR_W-1:0] ptr;
  logic [STACK_ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0]       ram_rdata;
  logic                    reg_hit;

  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(DEPTH);
    end else if (psel && penable && pwrite && reg_hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(capacity) : '0;

  // zero acts as one, anything above the depth as the depth
  always_comb begin
    if (capacity == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      eff_cap = COUNT_W'(DEPTH);
    end else begin
      eff_cap = COUNT_W'(capacity);
    end
  end

  assign count_dec = count - COUNT_W'(1);

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + COUNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign rd_addr = cmd.rd_top ? count_dec[STACK_ADDR_W-1:0] : ptr - STACK_ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_top || cmd.rd_next) begin
      ptr <= rd_addr;
    end
  end

  bls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[STACK_ADDR_W-1:0]),
    .wdata (push_value),
    .re    (cmd.rd_top || cmd.rd_next),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_nodata || cmd.ld_ram) begin
      is_empty <= (count_next == '0);
      is_full  <= (count_next >= eff_cap);
    end
    if (cmd.ld_nodata) begin
      data_value <= '0;
      status     <= cmd.status;
      last       <= 1'b1;
    end else if (cmd.ld_ram) begin
      data_value <= ram_rdata;
      status     <= ST_OK;
      last       <= cmd.last;
    end
  end

  assign stat.cnt_zero = (count == '0);
  assign stat.full     = (count >= eff_cap);
  assign stat.ptr_zero = (ptr == '0);
  assign stat.out_last = last;

endmodule

// ----- rtl/bls_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bls_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [bls_pkg::DATA_W-1:0]    data_value,
  input logic [bls_pkg::STATUS_W-1:0]         status,
  input logic                                 is_empty,
  input logic                                 is_full,
  input logic                                 last
);

  import bls_pkg::*;

  `ASSERT_CLK(a_reset_clears_out, clk, rst |=> !out_valid)

  `ASSERT_CLK_RST(a_out_hold, clk, rst,
    out_valid && out_stall |=>
      out_valid && $stable(data_value) && $stable(status) && $stable(last))

  `ASSERT_CLK_RST(a_overflow_item, clk, rst,
    out_valid && (status == ST_OVERFLOW) |-> is_full && last && (data_value == '0))

  `ASSERT_CLK_RST(a_underflow_item, clk, rst,
    out_valid && (status == ST_UNDERFLOW) |-> is_empty && last && (data_value == '0))

  `ASSERT_CLK_RST(a_empty_not_full, clk, rst, out_valid |-> !(is_empty && is_full))

endmodule

bind bounded_lifo_stack_unit bls_chk u_bls_chk (.*);

// ----- tb/bounded_lifo_stack_unit_test.sv -----
`timescale 1ns / 1ps

module bounded_lifo_stack_unit_test;
  import bls_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [PADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [STATUS_W-1:0] st;
    logic                empty;
    logic                full;
    logic                last;
  } stack_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [PADDR_W-1:0]  addr;
    opcode_t             op;
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] st;
    logic                empty;
    logic                full;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OPCODE_W-1:0]   opcode = OP_PUSH;
  logic [DATA_W-1:0]     push_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     data_value;
  logic [STATUS_W-1:0]   status;
  logic                  is_empty;
  logic                  is_full;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [DATA_W-1:0] stack_mem [DEPTH];
  int                stack_count = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_W'(DEPTH);

  stack_result_t fresh_results [$];
  stack_result_t results_due [$];
  plan_row_t     plan [$];

  int   errors = 0;
  int   cycle_count = 0;
  int   hold_count = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;

  bounded_lifo_stack_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_value (data_value),
    .status     (status),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic void note_result(logic [DATA_W-1:0] d, logic [STATUS_W-1:0] s,
                                      logic lst);
    stack_result_t r;
    r.data  = d;
    r.st    = s;
    r.empty = (stack_count == 0);
    r.full  = (stack_count >= cap_limit());
    r.last  = lst;
    fresh_results.push_back(r);
  endfunction

  task automatic apply_stack_op(input opcode_t op, input logic [DATA_W-1:0] v);
    int i;
    fresh_results.delete();
    case (op)
      OP_PUSH: begin
        if (stack_count >= cap_limit()) begin
          note_result('0, ST_OVERFLOW, 1'b1);
        end else begin
          stack_mem[stack_count] = v;
          stack_count++;
          note_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (stack_count == 0) begin
          note_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          stack_count--;
          note_result(stack_mem[stack_count], ST_OK, 1'b1);
        end
      end
      OP_PEEK: begin
        if (stack_count == 0) note_result('0, ST_UNDERFLOW, 1'b1);
        else note_result(stack_mem[stack_count-1], ST_OK, 1'b1);
      end
      default: begin
        if (stack_count == 0) begin
          note_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          for (i = stack_count; i > 0; i--) note_result(stack_mem[i-1], ST_OK, i == 1);
        end
      end
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    if ($urandom_range(9) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic opcode_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_PUSH;
    if (r < 65) return OP_POP;
    if (r < 80) return OP_PEEK;
    return OP_DUMP;
  endfunction

  function automatic void plan_cfg(logic [PADDR_W-1:0] a, logic [DATA_W-1:0] v);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.addr  = a;
    r.value = v;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(opcode_t op, logic [DATA_W-1:0] v);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.value = v;
    plan.push_back(r);
  endfunction

  function automatic void plan_typed(opcode_t op, logic [DATA_W-1:0] v,
                                     logic [STATUS_W-1:0] s, logic e, logic f);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_TYPED;
    r.op    = op;
    r.value = v;
    r.st    = s;
    r.empty = e;
    r.full  = f;
    plan.push_back(r);
  endfunction

  task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] v, input logic typed,
                           input stack_result_t want);
    opcode     <= op;
    push_value <= v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_stack_op(op, v);
    if (typed) begin
      results_due.push_back(want);
    end else begin
      foreach (fresh_results[k]) results_due.push_back(fresh_results[k]);
    end
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic settle_stack();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (a == CAP_ADDR) cap_reg = v[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // receiver side, with one long hold-off once requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, actual data %h status %h",
                 $time, data_value, status);
      end else begin
        want = results_due.pop_front();
        check_field("data_value", want.data, data_value);
        check_field("status", want.st, status);
        check_field("is_empty", want.empty, is_empty);
        check_field("is_full", want.full, is_full);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL bounded_lifo_stack_unit");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t     row;
    stack_result_t want;
    int            p;
    int            cap_val;

    // empty stack, extremes, capacity edge cases
    plan_typed(OP_POP,  $urandom, ST_UNDERFLOW, 1'b1, 1'b0);
    plan_typed(OP_PEEK, $urandom, ST_UNDERFLOW, 1'b1, 1'b0);
    plan_typed(OP_DUMP, $urandom, ST_UNDERFLOW, 1'b1, 1'b0);
    plan_typed(OP_PUSH, 32'h7FFF_FFFF, ST_OK, 1'b0, 1'b0);
    plan_typed(OP_PUSH, 32'h8000_0000, ST_OK, 1'b0, 1'b0);
    plan_typed(OP_PUSH, 32'h0000_0000, ST_OK, 1'b0, 1'b0);
    plan_typed(OP_PUSH, 32'hFFFF_FFFF, ST_OK, 1'b0, 1'b0);
    plan_item(OP_PEEK, $urandom);
    plan_item(OP_DUMP, $urandom);
    plan_item(OP_POP, $urandom);
    plan_item(OP_POP, $urandom);
    // capacity lowered to the current count
    plan_cfg(CAP_ADDR, 2);
    plan_typed(OP_PUSH, 32'h0000_1234, ST_OVERFLOW, 1'b0, 1'b1);
    plan_item(OP_POP, $urandom);
    plan_item(OP_POP, $urandom);
    plan_typed(OP_POP, $urandom, ST_UNDERFLOW, 1'b1, 1'b0);
    // zero capacity acts as one
    plan_cfg(CAP_ADDR, 0);
    plan_typed(OP_PUSH, 32'h5555_AAAA, ST_OK, 1'b0, 1'b1);
    plan_typed(OP_PUSH, 32'h0F0F_0F0F, ST_OVERFLOW, 1'b0, 1'b1);
    plan_item(OP_DUMP, $urandom);
    plan_cfg(SPARE_ADDR, 3);
    plan_typed(OP_PUSH, 32'h1234_5678, ST_OVERFLOW, 1'b0, 1'b1);
    plan_item(OP_POP, $urandom);
    // oversized capacity acts as depth
    plan_cfg(CAP_ADDR, 127);
    plan_typed(OP_PUSH, 32'hAAAA_5555, ST_OK, 1'b0, 1'b0);
    plan_item(OP_PEEK, $urandom);
    plan_item(OP_POP, $urandom);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        settle_stack();
        write_reg(row.addr, row.value);
      end else begin
        want.data  = '0;
        want.st    = row.st;
        want.empty = row.empty;
        want.full  = row.full;
        want.last  = 1'b1;
        send_item(row.op, row.value, row.kind == ROW_TYPED, want);
      end
    end

    // fill to depth while the receiver holds off, dump, then drain past empty
    settle_stack();
    write_reg(CAP_ADDR, DEPTH);
    hold_req <= 1'b1;
    while (stack_count < DEPTH) send_item(OP_PUSH, rand_word(), 1'b0, '0);
    send_item(OP_PUSH, rand_word(), 1'b0, '0);
    send_item(OP_DUMP, $urandom, 1'b0, '0);
    send_item(OP_PEEK, $urandom, 1'b0, '0);
    while (stack_count > 0) send_item(OP_POP, $urandom, 1'b0, '0);
    send_item(OP_POP, $urandom, 1'b0, '0);

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       cap_val = 1;
        1:       cap_val = 0;
        2:       cap_val = 127;
        3:       cap_val = $urandom_range(8, 2);
        4:       cap_val = $urandom_range(DEPTH, 1);
        default: cap_val = DEPTH;
      endcase
      settle_stack();
      write_reg(CAP_ADDR, cap_val);
      calm <= (p == 2);
      repeat (18) send_item(pick_op(), rand_word(), 1'b0, '0);
    end

    settle_stack();
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, results_due.size());
    end
    if (errors == 0) begin
      $display("PASS bounded_lifo_stack_unit");
    end else begin
      $display("FAIL bounded_lifo_stack_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_ram.sv
rtl/bls_ctrl.sv
rtl/bls_dp.sv
rtl/bounded_lifo_stack_unit.sv
rtl/bls_chk.sv
tb/bounded_lifo_stack_unit_test.sv
